// ===== hdl/gta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_pkg
// Shared types and constants for the greedy track association block.
// ----------------------------------------------------------------------------
package gta_pkg;

  localparam int MaxTracksDef = 16;
  localparam int MaxDetsDef   = 16;

  localparam int PosW     = 16;
  localparam int MotW     = 17;
  localparam int IdW      = 16;
  localparam int TimeW    = 32;
  localparam int LimW     = 16;
  localparam int LimSqW   = 32;
  localparam int LiveOutW = 5;
  localparam int DiffW    = 19;   // predicted minus detection, signed
  localparam int ProdW    = 2 * DiffW;
  localparam int SqW      = 35;   // one squared axis difference
  localparam int DistW    = 36;   // sum of two squares

  localparam int CmdQDepth = 4;
  localparam int ResQDepth = 2;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    EV_MATCH   = 2'd0,
    EV_NEW     = 2'd1,
    EV_REMOVE  = 2'd2,
    EV_SUMMARY = 2'd3
  } event_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_MEMIT,
    ST_NWALK,
    ST_NEMIT,
    ST_CWR,
    ST_RSCAN,
    ST_RPICK,
    ST_REMIT,
    ST_SUM
  } eng_state_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PosW-1:0]    x;
    logic [PosW-1:0]    y;
    logic [TimeW-1:0]   ftime;
  } cmd_t;

  typedef struct packed {
    event_kind_t          kind;
    logic [IdW-1:0]       id;
    logic [PosW-1:0]      lx;
    logic [PosW-1:0]      ly;
    logic [PosW-1:0]      cx;
    logic [PosW-1:0]      cy;
    logic [TimeW-1:0]     life;
    logic [LiveOutW-1:0]  live;
    logic                 ovf;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [IdW-1:0]          ident;
    logic [PosW-1:0]         pos_x;
    logic [PosW-1:0]         pos_y;
    logic signed [MotW-1:0]  mot_x;
    logic signed [MotW-1:0]  mot_y;
    logic [TimeW-1:0]        birth;
  } track_t;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } det_t;

endpackage

// ===== hdl/greedy_track_association.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_track_association
// Greedy nearest-neighbor association of detections to predicted tracks.
// ----------------------------------------------------------------------------
// Add-detection beats are taken one per cycle while the engine is idle, fed
// through a 4-beat queue. A close runs greedy rounds, each a scan of every
// track and detection pair, one pair per cycle through the distance pipe;
// rounds <= min(T,D)+1. Two slot walks follow, with one id-ordered selection
// scan per removed track between them; T = MAX_TRACKS and D = MAX_DETS.
// Reset clears flags, counters and queues at once; there is no clearing pass.
module greedy_track_association
  import gta_pkg::*;
#(
  parameter int MAX_TRACKS = MaxTracksDef,
  parameter int MAX_DETS   = MaxDetsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                command,
  input  logic [PosW-1:0]     center_x,
  input  logic [PosW-1:0]     center_y,
  input  logic [TimeW-1:0]    frame_time,
  input  logic                cfg_we,
  input  logic [LimW-1:0]     cfg_wdata,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          event_kind,
  output logic [IdW-1:0]      track_id,
  output logic [PosW-1:0]     last_x,
  output logic [PosW-1:0]     last_y,
  output logic [PosW-1:0]     cur_x,
  output logic [PosW-1:0]     cur_y,
  output logic [TimeW-1:0]    lifetime,
  output logic [LiveOutW-1:0] live_count,
  output logic                overflow,
  output logic                last_of_run
);

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_take;
  result_t res;
  logic    res_push;
  logic    res_full;
  result_t head;

  gta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .center_x   (center_x),
    .center_y   (center_y),
    .frame_time (frame_time),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  gta_engine #(
    .MAX_TRACKS (MAX_TRACKS),
    .MAX_DETS   (MAX_DETS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  gta_result_q u_result_q (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign event_kind  = head.kind;
  assign track_id    = head.id;
  assign last_x      = head.lx;
  assign last_y      = head.ly;
  assign cur_x       = head.cx;
  assign cur_y       = head.cy;
  assign lifetime    = head.life;
  assign live_count  = head.live;
  assign overflow    = head.ovf;
  assign last_of_run = head.last;

endmodule

// ===== hdl/gta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gta_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_front
// Accepts input beats, decodes the command and queues them for the engine.
// ----------------------------------------------------------------------------
module gta_front
  import gta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             command,
  input  logic [PosW-1:0]  center_x,
  input  logic [PosW-1:0]  center_y,
  input  logic [TimeW-1:0] frame_time,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);

  localparam int QAW = $clog2(CmdQDepth);
  localparam int QCW = $clog2(CmdQDepth + 1);
  localparam logic [QCW-1:0] QCap = QCW'(CmdQDepth);

  cmd_t           q_mem [CmdQDepth];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  cmd_t           cmd_in;
  logic           do_wr;
  logic           do_rd;

  always_comb begin
    cmd_in.x     = center_x;
    cmd_in.y     = center_y;
    cmd_in.ftime = frame_time;
    unique case (command)
      1'b0:    cmd_in.kind = CMD_ADD;
      1'b1:    cmd_in.kind = CMD_CLOSE;
      default: cmd_in.kind = CMD_ADD;
    endcase
  end

  assign full      = (count == QCap);
  assign cmd_valid = (count != '0);
  assign cmd       = q_mem[rd_ptr];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_mem[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/gta_result_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_result_q
// Short result queue that decouples the engine from the consumer.
// ----------------------------------------------------------------------------
module gta_result_q
  import gta_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res_in,
  output logic    res_full,
  input  logic    pop,
  output logic    empty,
  output result_t head
);

  localparam int QAW = $clog2(ResQDepth);
  localparam int QCW = $clog2(ResQDepth + 1);
  localparam logic [QCW-1:0] QCap = QCW'(ResQDepth);

  result_t        q_mem [ResQDepth];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_wr;
  logic           do_rd;

  assign res_full = (count == QCap);
  assign empty    = (count == '0);
  assign head     = q_mem[rd_ptr];
  assign do_wr    = res_push && !res_full;
  assign do_rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_mem[wr_ptr] <= res_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/gta_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_engine
// Back end: stores detections, runs greedy matching, opens and closes tracks.
// ----------------------------------------------------------------------------
module gta_engine
  import gta_pkg::*;
#(
  parameter int MAX_TRACKS = MaxTracksDef,
  parameter int MAX_DETS   = MaxDetsDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_take,
  input  logic            cfg_we,
  input  logic [LimW-1:0] cfg_wdata,
  output logic            res_push,
  output result_t         res,
  input  logic            res_full
);

  localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int CW = $clog2(MAX_DETS + 1);
  localparam int LW = $clog2(MAX_TRACKS + 1);
  localparam logic [TW-1:0] TLast = TW'(MAX_TRACKS - 1);
  localparam logic [DW-1:0] DLast = DW'(MAX_DETS - 1);
  localparam logic [CW-1:0] DCap  = CW'(MAX_DETS);
  localparam logic [LW-1:0] TCap  = LW'(MAX_TRACKS);

  eng_state_t state, state_next;

  logic [LimW-1:0]   limit;
  logic [LimSqW-1:0] lim2;
  logic [LimSqW-1:0] lim2_full;
  logic [TimeW-1:0]  now;
  logic [LW-1:0]     start_live;
  logic [LW-1:0]     live_acc;
  logic [LW-1:0]     live_tracks;
  logic              ovf;
  logic [IdW-1:0]    next_id;
  logic [IdW-1:0]    new_id;
  logic [CW-1:0]     det_count;
  logic              dropped;

  logic [MAX_TRACKS-1:0] valid;
  logic [MAX_TRACKS-1:0] tmatch;
  logic [MAX_TRACKS-1:0] rdone;
  logic [MAX_DETS-1:0]   dmatch;

  // pair scan pipeline
  logic                    run;
  logic [TW-1:0]           ts;
  logic [DW-1:0]           ds;
  logic                    v1, v2, v3;
  logic [TW-1:0]           t1, t2, t3;
  logic [DW-1:0]           d1, d2, d3;
  logic signed [DiffW-1:0] dx2, dy2;
  logic [IdW-1:0]          id2, id3;
  logic [SqW-1:0]          sqx3, sqy3;
  logic                    elig;
  logic signed [DiffW-1:0] px, py, dx, dy;
  logic signed [ProdW-1:0] px_sq, py_sq;
  logic [DistW-1:0]        q;
  logic                    cand;

  logic              found;
  logic [DistW-1:0]  bq;
  logic [IdW-1:0]    bid;
  logic [TW-1:0]     bt;
  logic [DW-1:0]     bd;

  logic              rfound;
  logic [IdW-1:0]    rbid;
  logic [TW-1:0]     br;

  logic [LW-1:0]     s_ptr;
  logic [CW-1:0]     d_w;
  logic              pass2;
  logic              slot_free;
  logic              walk_done;

  // memories
  logic                      trk_we;
  logic [TW-1:0]             trk_waddr;
  track_t                    trk_wdata;
  logic [TW-1:0]             trk_raddr;
  logic [$bits(track_t)-1:0] trk_rdata_raw;
  track_t                    trk_rd;
  logic                      det_we;
  logic [DW-1:0]             det_waddr;
  det_t                      det_wdata;
  logic [DW-1:0]             det_raddr;
  logic [$bits(det_t)-1:0]   det_rdata_raw;
  det_t                      det_rd;

  gta_ram #(.WIDTH($bits(track_t)), .DEPTH(MAX_TRACKS)) u_trk_ram (
    .clk   (clk),
    .we    (trk_we),
    .waddr (trk_waddr),
    .wdata (trk_wdata),
    .raddr (trk_raddr),
    .rdata (trk_rdata_raw)
  );

  gta_ram #(.WIDTH($bits(det_t)), .DEPTH(MAX_DETS)) u_det_ram (
    .clk   (clk),
    .we    (det_we),
    .waddr (det_waddr),
    .wdata (det_wdata),
    .raddr (det_raddr),
    .rdata (det_rdata_raw)
  );

  assign trk_rd = trk_rdata_raw;
  assign det_rd = det_rdata_raw;

  assign lim2_full = limit * limit;
  assign walk_done = (d_w == det_count);
  assign slot_free = !(valid[s_ptr[TW-1:0]] && tmatch[s_ptr[TW-1:0]]);

  // prediction minus detection, exact and signed
  always_comb begin
    px = $signed({3'b000, trk_rd.pos_x}) + $signed({{2{trk_rd.mot_x[MotW-1]}}, trk_rd.mot_x});
    py = $signed({3'b000, trk_rd.pos_y}) + $signed({{2{trk_rd.mot_y[MotW-1]}}, trk_rd.mot_y});
    dx = px - $signed({3'b000, det_rd.x});
    dy = py - $signed({3'b000, det_rd.y});
  end

  assign px_sq = dx2 * dx2;
  assign py_sq = dy2 * dy2;
  assign q     = {1'b0, sqx3} + {1'b0, sqy3};
  // ordering key is distance, then track id, then scan order
  assign cand  = v3 && (q < {{(DistW-LimSqW){1'b0}}, lim2}) &&
                 (!found || q < bq || (q == bq && id3 < bid));

  always_comb begin
    if (state == ST_SCAN) begin
      elig = valid[ts] && !tmatch[ts] && (CW'(ds) < det_count) && !dmatch[ds];
    end else begin
      elig = valid[ts] && !tmatch[ts] && !rdone[ts];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_valid && cmd.kind == CMD_CLOSE) state_next = ST_INIT;
      ST_INIT:  state_next = ST_SCAN;
      ST_SCAN:  if (!run && !v1 && !v2 && !v3) state_next = ST_PICK;
      ST_PICK:  state_next = found ? ST_MEMIT : ST_NWALK;
      ST_MEMIT: if (!res_full) state_next = ST_SCAN;
      ST_NWALK: begin
        if (walk_done) begin
          state_next = pass2 ? ST_SUM : ST_RSCAN;
        end else if (!dmatch[d_w[DW-1:0]] && s_ptr != TCap && slot_free) begin
          state_next = pass2 ? ST_CWR : ST_NEMIT;
        end
      end
      ST_NEMIT: if (!res_full) state_next = ST_NWALK;
      ST_CWR:   state_next = ST_NWALK;
      ST_RSCAN: if (!run && !v1) state_next = ST_RPICK;
      ST_RPICK: state_next = rfound ? ST_REMIT : ST_NWALK;
      ST_REMIT: if (!res_full) state_next = ST_RSCAN;
      ST_SUM:   if (!res_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs, memory ports
  always_comb begin
    cmd_take  = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    trk_we    = 1'b0;
    trk_waddr = bt;
    trk_wdata = '0;
    trk_raddr = ts;
    det_we    = 1'b0;
    det_waddr = det_count[DW-1:0];
    det_wdata.x = cmd.x;
    det_wdata.y = cmd.y;
    det_raddr = ds;
    unique case (state)
      ST_IDLE: begin
        cmd_take = cmd_valid;
        det_we   = cmd_valid && cmd.kind == CMD_ADD && det_count < DCap;
      end
      ST_PICK: begin
        trk_raddr = bt;
        det_raddr = bd;
      end
      ST_MEMIT: begin
        trk_raddr       = bt;
        det_raddr       = bd;
        res_push        = !res_full;
        res.kind        = EV_MATCH;
        res.id          = trk_rd.ident;
        res.lx          = trk_rd.pos_x;
        res.ly          = trk_rd.pos_y;
        res.cx          = det_rd.x;
        res.cy          = det_rd.y;
        res.life        = now - trk_rd.birth;
        trk_we          = !res_full;
        trk_wdata.ident = trk_rd.ident;
        trk_wdata.pos_x = det_rd.x;
        trk_wdata.pos_y = det_rd.y;
        trk_wdata.mot_x = $signed({1'b0, det_rd.x}) - $signed({1'b0, trk_rd.pos_x});
        trk_wdata.mot_y = $signed({1'b0, det_rd.y}) - $signed({1'b0, trk_rd.pos_y});
        trk_wdata.birth = trk_rd.birth;
      end
      ST_NWALK: det_raddr = d_w[DW-1:0];
      ST_NEMIT: begin
        det_raddr = d_w[DW-1:0];
        res_push  = !res_full;
        res.kind  = EV_NEW;
        res.id    = new_id;
        res.cx    = det_rd.x;
        res.cy    = det_rd.y;
      end
      ST_CWR: begin
        det_raddr       = d_w[DW-1:0];
        trk_we          = 1'b1;
        trk_waddr       = s_ptr[TW-1:0];
        trk_wdata.ident = next_id;
        trk_wdata.pos_x = det_rd.x;
        trk_wdata.pos_y = det_rd.y;
        trk_wdata.birth = now;
      end
      ST_RPICK: trk_raddr = br;
      ST_REMIT: begin
        trk_raddr = br;
        res_push  = !res_full;
        res.kind  = EV_REMOVE;
        res.id    = trk_rd.ident;
        res.lx    = trk_rd.pos_x;
        res.ly    = trk_rd.pos_y;
        res.life  = now - trk_rd.birth;
      end
      ST_SUM: begin
        res_push = !res_full;
        res.kind = EV_SUMMARY;
        res.live = LiveOutW'(start_live);
        res.ovf  = ovf;
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    // payload of the scan pipeline
    t1   <= ts;
    d1   <= ds;
    t2   <= t1;
    d2   <= d1;
    id2  <= trk_rd.ident;
    dx2  <= dx;
    dy2  <= dy;
    t3   <= t2;
    d3   <= d2;
    id3  <= id2;
    sqx3 <= px_sq[SqW-1:0];
    sqy3 <= py_sq[SqW-1:0];
    if (rst) begin
      state       <= ST_IDLE;
      limit       <= '0;
      run         <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      found       <= 1'b0;
      rfound      <= 1'b0;
      pass2       <= 1'b0;
      det_count   <= '0;
      dropped     <= 1'b0;
      next_id     <= '0;
      live_tracks <= '0;
      live_acc    <= '0;
      valid       <= '0;
      tmatch      <= '0;
      dmatch      <= '0;
      rdone       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) limit <= cfg_wdata;
      v1 <= run && elig;
      v2 <= v1 && (state == ST_SCAN);
      v3 <= v2;
      if (cand) begin
        found <= 1'b1;
        bq    <= q;
        bid   <= id3;
        bt    <= t3;
        bd    <= d3;
      end
      if (state == ST_RSCAN && v1 && (!rfound || trk_rd.ident < rbid)) begin
        rfound <= 1'b1;
        rbid   <= trk_rd.ident;
        br     <= t1;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind == CMD_CLOSE) begin
              now <= cmd.ftime;
            end else if (det_count < DCap) begin
              det_count <= det_count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        ST_INIT: begin
          lim2       <= lim2_full;
          tmatch     <= '0;
          dmatch     <= '0;
          rdone      <= '0;
          found      <= 1'b0;
          live_acc   <= '0;
          start_live <= live_tracks;
          ovf        <= dropped;
          ts         <= '0;
          ds         <= '0;
          run        <= 1'b1;
        end
        ST_SCAN: begin
          if (run) begin
            if (ds == DLast) begin
              ds <= '0;
              if (ts == TLast) begin
                run <= 1'b0;
              end else begin
                ts <= ts + 1'b1;
              end
            end else begin
              ds <= ds + 1'b1;
            end
          end
        end
        ST_PICK: begin
          if (!found) begin
            d_w    <= '0;
            s_ptr  <= '0;
            pass2  <= 1'b0;
            new_id <= next_id;
          end
        end
        ST_MEMIT: begin
          if (!res_full) begin
            tmatch[bt] <= 1'b1;
            dmatch[bd] <= 1'b1;
            live_acc   <= live_acc + 1'b1;
            found      <= 1'b0;
            ts         <= '0;
            ds         <= '0;
            run        <= 1'b1;
          end
        end
        ST_NWALK: begin
          if (walk_done) begin
            if (!pass2) begin
              ts     <= '0;
              run    <= 1'b1;
              rfound <= 1'b0;
            end
          end else if (dmatch[d_w[DW-1:0]]) begin
            d_w <= d_w + 1'b1;
          end else if (s_ptr == TCap) begin
            // track table full, detection gets no track
            ovf <= 1'b1;
            d_w <= d_w + 1'b1;
          end else if (!slot_free) begin
            s_ptr <= s_ptr + 1'b1;
          end
        end
        ST_NEMIT: begin
          if (!res_full) begin
            new_id <= new_id + 1'b1;
            s_ptr  <= s_ptr + 1'b1;
            d_w    <= d_w + 1'b1;
          end
        end
        ST_CWR: begin
          valid[s_ptr[TW-1:0]] <= 1'b1;
          next_id  <= next_id + 1'b1;
          live_acc <= live_acc + 1'b1;
          s_ptr    <= s_ptr + 1'b1;
          d_w      <= d_w + 1'b1;
        end
        ST_RSCAN: begin
          if (run) begin
            if (ts == TLast) begin
              run <= 1'b0;
            end else begin
              ts <= ts + 1'b1;
            end
          end
        end
        ST_RPICK: begin
          if (!rfound) begin
            // unmatched tracks close, then the commit pass reuses their slots
            valid <= valid & tmatch;
            d_w   <= '0;
            s_ptr <= '0;
            pass2 <= 1'b1;
          end
        end
        ST_REMIT: begin
          if (!res_full) begin
            rdone[br] <= 1'b1;
            rfound    <= 1'b0;
            ts        <= '0;
            run       <= 1'b1;
          end
        end
        ST_SUM: begin
          if (!res_full) begin
            det_count   <= '0;
            dropped     <= 1'b0;
            live_tracks <= live_acc;
          end
        end
        default: ;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat pushed into a full queue");

  a_det_bound: assert property (@(posedge clk) disable iff (rst)
    det_count <= DCap)
    else $error("detection count beyond table size");

  a_best_limit: assert property (@(posedge clk) disable iff (rst)
    found |-> (bq < {{(DistW-LimSqW){1'b0}}, lim2}))
    else $error("held best pair is not inside the distance limit");

  a_run_scope: assert property (@(posedge clk) disable iff (rst)
    run |-> (state == ST_SCAN || state == ST_RSCAN))
    else $error("scan counter running outside a scan");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_acc <= TCap)
    else $error("live track count beyond table size");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Frame-level check of greedy track association. Detection and close beats are
// pushed in bursts while results are popped on a stall pattern. Every result is
// compared field by field against an in-bench association predictor.
// ----------------------------------------------------------------------------
module testbench;
  import gta_pkg::*;

  localparam int NT = 16;
  localparam int ND = 16;
  localparam int WatchLimit = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic command = 1'b0;
  logic [15:0] center_x = '0;
  logic [15:0] center_y = '0;
  logic [31:0] frame_time = '0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] event_kind;
  logic [15:0] track_id, last_x, last_y, cur_x, cur_y;
  logic [31:0] lifetime;
  logic [4:0] live_count;
  logic overflow, last_of_run;

  greedy_track_association uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .center_x(center_x), .center_y(center_y), .frame_time(frame_time),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .empty(empty), .pop(pop),
    .event_kind(event_kind), .track_id(track_id), .last_x(last_x),
    .last_y(last_y), .cur_x(cur_x), .cur_y(cur_y), .lifetime(lifetime),
    .live_count(live_count), .overflow(overflow), .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] lim;
  logic tv [NT];
  logic [15:0] tid [NT];
  logic [15:0] tpx [NT];
  logic [15:0] tpy [NT];
  logic signed [16:0] tmx [NT];
  logic signed [16:0] tmy [NT];
  logic [31:0] tbirth [NT];
  logic [15:0] dx_tab [ND];
  logic [15:0] dy_tab [ND];
  int dcount;
  logic ddrop;
  logic [15:0] next_id;
  int live_n;

  result_t events_due[$];
  int errors = 0;
  int frames = 0;
  int dets_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %0d: %s got %0h want %0h", errors, what, got, want);
  endtask

  function automatic result_t mk(event_kind_t k, logic [15:0] id, logic [15:0] lx,
                                 logic [15:0] ly, logic [15:0] cx, logic [15:0] cy,
                                 logic [31:0] life, logic [4:0] lv, logic ov, logic ls);
    result_t r;
    r.kind = k; r.id = id; r.lx = lx; r.ly = ly; r.cx = cx; r.cy = cy;
    r.life = life; r.live = lv; r.ovf = ov; r.last = ls;
    return r;
  endfunction

  function automatic longint sqdist(int t, int d);
    longint px, py, ex, ey;
    px = longint'(tpx[t]) + longint'(tmx[t]);
    py = longint'(tpy[t]) + longint'(tmy[t]);
    ex = px - longint'(dx_tab[d]);
    ey = py - longint'(dy_tab[d]);
    return ex * ex + ey * ey;
  endfunction

  task automatic associate_frame(input logic [31:0] now);
    logic tm [NT];
    logic dm [ND];
    int rem[$];
    result_t rem_ev[$];
    int bt, bd, slot, start_live, v, j;
    longint q, best, lim2;
    logic found, ov;
    start_live = live_n;
    ov = ddrop;
    lim2 = longint'(lim) * longint'(lim);
    for (int t = 0; t < NT; t++) tm[t] = 1'b0;
    for (int d = 0; d < ND; d++) dm[d] = 1'b0;
    forever begin
      found = 1'b0; bt = 0; bd = 0; best = 0;
      for (int t = 0; t < NT; t++) begin
        if (tv[t] && !tm[t]) begin
          for (int d = 0; d < dcount; d++) begin
            if (!dm[d]) begin
              q = sqdist(t, d);
              if (q < lim2 && (!found || q < best || (q == best && tid[t] < tid[bt]))) begin
                found = 1'b1; bt = t; bd = d; best = q;
              end
            end
          end
        end
      end
      if (!found) break;
      tm[bt] = 1'b1;
      dm[bd] = 1'b1;
      events_due.push_back(mk(EV_MATCH, tid[bt], tpx[bt], tpy[bt], dx_tab[bd], dy_tab[bd],
                              now - tbirth[bt], '0, 1'b0, 1'b0));
      tmx[bt] = $signed({1'b0, dx_tab[bd]}) - $signed({1'b0, tpx[bt]});
      tmy[bt] = $signed({1'b0, dy_tab[bd]}) - $signed({1'b0, tpy[bt]});
      tpx[bt] = dx_tab[bd];
      tpy[bt] = dy_tab[bd];
    end
    for (int t = 0; t < NT; t++)
      if (tv[t] && !tm[t]) rem.push_back(t);
    // insertion sort by id, stable on slot
    for (int i = 1; i < rem.size(); i++) begin
      v = rem[i]; j = i;
      while (j > 0 && tid[rem[j-1]] > tid[v]) begin
        rem[j] = rem[j-1];
        j--;
      end
      rem[j] = v;
    end
    foreach (rem[i]) begin
      rem_ev.push_back(mk(EV_REMOVE, tid[rem[i]], tpx[rem[i]], tpy[rem[i]], '0, '0,
                          now - tbirth[rem[i]], '0, 1'b0, 1'b0));
      tv[rem[i]] = 1'b0;
    end
    for (int d = 0; d < dcount; d++) begin
      if (!dm[d]) begin
        slot = -1;
        for (int t = 0; t < NT; t++)
          if (!tv[t] && slot < 0) slot = t;
        if (slot < 0) ov = 1'b1;
        else begin
          tv[slot] = 1'b1; tid[slot] = next_id;
          tpx[slot] = dx_tab[d]; tpy[slot] = dy_tab[d];
          tmx[slot] = '0; tmy[slot] = '0; tbirth[slot] = now;
          events_due.push_back(mk(EV_NEW, next_id, '0, '0, dx_tab[d], dy_tab[d], '0, '0,
                                  1'b0, 1'b0));
          next_id = next_id + 16'd1;
        end
      end
    end
    foreach (rem_ev[i]) events_due.push_back(rem_ev[i]);
    live_n = 0;
    for (int t = 0; t < NT; t++) if (tv[t]) live_n++;
    events_due.push_back(mk(EV_SUMMARY, '0, '0, '0, '0, '0, '0, start_live[4:0], ov, 1'b1));
    dcount = 0;
    ddrop = 1'b0;
  endtask

  // burst/gap state for the sender
  int burst_left = 0;

  // push stays high between beats of a burst; gaps and drains drop it
  task automatic send_beat(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                           input logic [31:0] ft);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    command <= cmd; center_x <= x; center_y <= y; frame_time <= ft;
    @(posedge clk);
    while (full) @(posedge clk);
    if (cmd == CMD_ADD) begin
      dets_sent++;
      if (dcount < ND) begin
        dx_tab[dcount] = x; dy_tab[dcount] = y; dcount++;
      end else ddrop = 1'b1;
    end else begin
      frames++;
      associate_frame(ft);
    end
    @(negedge clk);
  endtask

  task automatic add_det(input logic [15:0] x, input logic [15:0] y);
    send_beat(CMD_ADD, x, y, $urandom);
  endtask

  task automatic close_frame(input logic [31:0] ft);
    send_beat(CMD_CLOSE, 16'($urandom), 16'($urandom), ft);
  endtask

  task automatic drain_and_set_limit(input logic [15:0] v);
    push <= 1'b0;
    burst_left = 0;
    while (events_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim = v;
  endtask

  // result checker with its own stall pattern
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (events_due.size() == 0) report("unexpected result kind", 32'(event_kind), 32'd0);
      else begin
        result_t w;
        w = events_due.pop_front();
        if (event_kind != w.kind) report("event_kind", 32'(event_kind), 32'(w.kind));
        if (track_id != w.id) report("track_id", 32'(track_id), 32'(w.id));
        if (last_x != w.lx) report("last_x", 32'(last_x), 32'(w.lx));
        if (last_y != w.ly) report("last_y", 32'(last_y), 32'(w.ly));
        if (cur_x != w.cx) report("cur_x", 32'(cur_x), 32'(w.cx));
        if (cur_y != w.cy) report("cur_y", 32'(cur_y), 32'(w.cy));
        if (lifetime != w.life) report("lifetime", lifetime, w.life);
        if (live_count != w.live) report("live_count", 32'(live_count), 32'(w.live));
        if (overflow != w.ovf) report("overflow", 32'(overflow), 32'(w.ovf));
        if (last_of_run != w.last) report("last_of_run", 32'(last_of_run), 32'(w.last));
      end
    end
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("testbench: done, errors");
      $finish;
    end
  end

  int pop_phase = 0;
  always @(negedge clk) begin
    pop_phase = (pop_phase + 1) % 64;
    // long no-stall stretch, then random stalls
    if (pop_phase < 20) pop <= 1'b1;
    else pop <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_no_limit;
    add_det(16'h0000, 16'h0000);
    add_det(16'hffff, 16'hffff);
    close_frame(32'h0000_0010);
    close_frame(32'h0000_0000);
  endtask

  task automatic test_match_and_motion;
    drain_and_set_limit(16'hffff);
    add_det(16'h0100, 16'h0100);
    add_det(16'h8000, 16'h8000);
    close_frame(32'd100);
    add_det(16'h0110, 16'h0120);
    add_det(16'h8010, 16'h7ff0);
    close_frame(32'd200);
    add_det(16'h0120, 16'h0140);
    close_frame(32'hffff_fff0);
    // equal distances: tie goes to the earlier detection
    add_det(16'h4000, 16'h4000);
    add_det(16'h4000, 16'h4000);
    close_frame(32'd5);
    add_det(16'h4000, 16'h4000);
    close_frame(32'd6);
  endtask

  task automatic test_tables_full;
    drain_and_set_limit(16'h0000);
    for (int i = 0; i < 18; i++) add_det(16'(i * 3000), 16'hffff - 16'(i * 7));
    close_frame(32'd1000);
    // all 16 tracks live and unmatched; new detections can reuse their slots
    for (int i = 0; i < 3; i++) add_det(16'($urandom), 16'($urandom));
    close_frame(32'd2000);
    // prediction off the picture: a track moving fast toward the edge
    drain_and_set_limit(16'hffff);
    add_det(16'hfff0, 16'h0010);
    close_frame(32'd1);
    add_det(16'h0010, 16'hfff0);
    close_frame(32'd2);
    add_det(16'h0000, 16'hffff);
    close_frame(32'd3);
  endtask

  task automatic test_random_frames(input int budget);
    int n, base_x, base_y, sent;
    sent = 0;
    while (sent < budget) begin
      if (sent > 10 && sent < 20) drain_and_set_limit($urandom_range(0, 1) ? 16'd0 :
                                                     16'($urandom_range(1, 4000)));
      else if ($urandom_range(0, 9) == 0) drain_and_set_limit(16'($urandom));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
      base_x = $urandom_range(0, 65535);
      base_y = $urandom_range(0, 65535);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) add_det(16'($urandom), 16'($urandom));
        else add_det(16'(base_x + $urandom_range(0, 512) * i),
                     16'(base_y + $urandom_range(0, 512)));
        sent++;
      end
      close_frame($urandom);
      sent++;
    end
  endtask

  initial begin
    lim = '0;
    for (int t = 0; t < NT; t++) begin
      tv[t] = 1'b0; tid[t] = '0; tpx[t] = '0; tpy[t] = '0;
      tmx[t] = '0; tmy[t] = '0; tbirth[t] = '0;
    end
    dcount = 0; ddrop = 1'b0; next_id = '0; live_n = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_no_limit;
    test_match_and_motion;
    test_tables_full;
    test_random_frames(30);
    drain_and_set_limit(16'hffff);
    test_random_frames(30);
    push <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("covered %0d frames, %0d detections, %0d results", frames, dets_sent,
             results_seen);
    $display("limits from zero to full scale, table overflow and id ordering exercised");
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
